// ===== hw/rtl/sad_pkg.sv =====
// shared types and codes of the slot allocator
package sad_pkg;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_CHECK   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_RECLAIM = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_TYPE = 3'd1,
    ST_NO_SPACE = 3'd2,
    ST_PENDING  = 3'd3,
    ST_MISMATCH = 3'd4,
    ST_RELEASED = 3'd5,
    ST_NOTHING  = 3'd6,
    ST_BAD_SLOT = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    K_DONE,
    K_ALLOC,
    K_CHECK,
    K_RELEASE,
    K_RECLAIM
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    status_t     status;
    logic        type_ok;
    logic [1:0]  type_code;
    logic [9:0]  slot;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [9:0]  slot;
  } result_t;

endpackage

// ===== hw/rtl/sad_fifo.sv =====
// small register queue between the allocator stages
module sad_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/sad_front.sv =====
// request decoder: range and type checks, command classification
module sad_front #(
  parameter int SLOTS      = 1024,
  parameter int TYPE_COUNT = 2
) (
  input  logic          [1:0] action,
  input  logic          [1:0] type_code,
  input  logic          [9:0] slot,
  output sad_pkg::cmd_t       cmd
);

  logic in_range;
  logic type_ok;

  assign in_range = ({22'd0, slot} < 32'(SLOTS));
  assign type_ok  = ({1'b0, type_code} < 3'(TYPE_COUNT));

  always_comb begin
    cmd.kind      = sad_pkg::K_DONE;
    cmd.status    = sad_pkg::ST_OK;
    cmd.type_ok   = type_ok;
    cmd.type_code = type_code;
    cmd.slot      = slot;
    unique case (sad_pkg::action_t'(action))
      sad_pkg::ACT_ALLOC: begin
        if (type_ok) begin
          cmd.kind = sad_pkg::K_ALLOC;
        end else begin
          cmd.status = sad_pkg::ST_BAD_TYPE;
        end
      end
      sad_pkg::ACT_CHECK: begin
        if (in_range) begin
          cmd.kind = sad_pkg::K_CHECK;
        end else begin
          cmd.status = sad_pkg::ST_BAD_SLOT;
        end
      end
      sad_pkg::ACT_RELEASE: begin
        if (in_range) begin
          cmd.kind = sad_pkg::K_RELEASE;
        end else begin
          cmd.status = sad_pkg::ST_BAD_SLOT;
        end
      end
      sad_pkg::ACT_RECLAIM: begin
        cmd.kind = sad_pkg::K_RECLAIM;
      end
      default: begin
        cmd.kind = sad_pkg::K_DONE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/sad_back.sv =====
// command sequencer: bump counter, free stack, pending list and slot memories
module sad_back #(
  parameter int SLOTS = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [$bits(sad_pkg::cmd_t)-1:0]      cmd_data,
  input  logic                                  cmd_empty,
  output logic                                  cmd_pop,
  output logic [$bits(sad_pkg::result_t)-1:0]   res_data,
  input  logic                                  res_full,
  output logic                                  res_push
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SPLICED,
    S_POP,
    S_LOOK
  } state_t;

  state_t            state_r, state_nxt;
  sad_pkg::cmd_t     cmd_r, cmd_nxt;
  sad_pkg::cmd_t     head;
  sad_pkg::result_t  res;
  logic [SW:0]       bump_r, bump_nxt;
  logic [SW-1:0]     free_head_r, free_head_nxt;
  logic              free_v_r, free_v_nxt;
  logic [SW-1:0]     rel_head_r, rel_head_nxt;
  logic              rel_v_r, rel_v_nxt;
  logic [SW-1:0]     rel_tail_r, rel_tail_nxt;

  logic [1:0]        tag_mem [SLOTS];
  logic              pend_mem [SLOTS];
  logic [SW-1:0]     link_mem [SLOTS];
  logic [1:0]        tag_rd_r;
  logic              pend_rd_r;
  logic [SW-1:0]     link_rd_r;

  logic [SW-1:0]     rd_addr;
  logic [SW-1:0]     wr_addr;
  logic              tag_we, pend_we, pend_wd;
  logic [1:0]        tag_wd;
  logic [SW-1:0]     link_wa, link_wd;
  logic              link_we;

  logic [SW-1:0]     head_idx, cmd_idx;
  logic              written, pending;

  assign head     = sad_pkg::cmd_t'(cmd_data);
  assign head_idx = SW'(head.slot);
  assign cmd_idx  = SW'(cmd_r.slot);
  assign written  = ({1'b0, cmd_idx} < bump_r);
  assign pending  = written && pend_rd_r;
  assign res_data = res;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    bump_nxt      = bump_r;
    free_head_nxt = free_head_r;
    free_v_nxt    = free_v_r;
    rel_head_nxt  = rel_head_r;
    rel_v_nxt     = rel_v_r;
    rel_tail_nxt  = rel_tail_r;
    cmd_pop       = 1'b0;
    res_push      = 1'b0;
    res.status    = sad_pkg::ST_OK;
    res.slot      = cmd_r.slot;
    rd_addr       = free_head_r;
    wr_addr       = free_head_r;
    tag_we        = 1'b0;
    tag_wd        = cmd_r.type_code;
    pend_we       = 1'b0;
    pend_wd       = 1'b0;
    link_we       = 1'b0;
    link_wa       = rel_tail_r;
    link_wd       = rel_tail_r;
    unique case (state_r)
      S_IDLE: begin
        rd_addr = head_idx;
        if (!cmd_empty && !res_full) begin
          cmd_pop  = 1'b1;
          cmd_nxt  = head;
          res.slot = head.slot;
          unique case (head.kind)
            sad_pkg::K_DONE: begin
              res_push   = 1'b1;
              res.status = head.status;
            end
            sad_pkg::K_ALLOC: begin
              if (bump_r < (SW + 1)'(SLOTS)) begin
                wr_addr  = bump_r[SW-1:0];
                tag_we   = 1'b1;
                tag_wd   = head.type_code;
                pend_we  = 1'b1;
                bump_nxt = bump_r + 1'b1;
                res_push = 1'b1;
                res.slot = 10'(bump_r[SW-1:0]);
              end else if (free_v_r) begin
                rd_addr   = free_head_r;
                state_nxt = S_POP;
              end else if (rel_v_r) begin
                // splice the pending list onto the empty free stack
                link_we       = 1'b1;
                free_head_nxt = rel_head_r;
                free_v_nxt    = 1'b1;
                rel_v_nxt     = 1'b0;
                state_nxt     = S_SPLICED;
              end else begin
                res_push   = 1'b1;
                res.status = sad_pkg::ST_NO_SPACE;
              end
            end
            sad_pkg::K_CHECK, sad_pkg::K_RELEASE: begin
              state_nxt = S_LOOK;
            end
            sad_pkg::K_RECLAIM: begin
              res_push = 1'b1;
              if (rel_v_r) begin
                link_we       = 1'b1;
                link_wd       = free_v_r ? free_head_r : rel_tail_r;
                free_head_nxt = rel_head_r;
                free_v_nxt    = 1'b1;
                rel_v_nxt     = 1'b0;
              end else begin
                res.status = sad_pkg::ST_NOTHING;
              end
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      S_SPLICED: begin
        state_nxt = S_POP;
      end
      S_POP: begin
        tag_we        = 1'b1;
        pend_we       = 1'b1;
        free_head_nxt = link_rd_r;
        free_v_nxt    = !((link_rd_r == free_head_r) ||
                          ({1'b0, link_rd_r} >= (SW + 1)'(SLOTS)));
        res_push      = 1'b1;
        res.slot      = 10'(free_head_r);
        state_nxt     = S_IDLE;
      end
      S_LOOK: begin
        res_push  = 1'b1;
        state_nxt = S_IDLE;
        wr_addr   = cmd_idx;
        if (cmd_r.kind == sad_pkg::K_CHECK) begin
          if (pending) begin
            res.status = sad_pkg::ST_PENDING;
          end else if (!cmd_r.type_ok) begin
            res.status = sad_pkg::ST_BAD_TYPE;
          end else if (!written || (tag_rd_r != cmd_r.type_code)) begin
            res.status = sad_pkg::ST_MISMATCH;
          end
        end else begin
          if (!written) begin
            res.status = sad_pkg::ST_BAD_SLOT;
          end else if (pending) begin
            res.status = sad_pkg::ST_RELEASED;
          end else begin
            pend_we      = 1'b1;
            pend_wd      = 1'b1;
            link_we      = 1'b1;
            link_wa      = cmd_idx;
            link_wd      = rel_v_r ? rel_head_r : cmd_idx;
            rel_tail_nxt = rel_v_r ? rel_tail_r : cmd_idx;
            rel_head_nxt = cmd_idx;
            rel_v_nxt    = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bump_r      <= '0;
      free_v_r    <= 1'b0;
      rel_v_r     <= 1'b0;
      rel_tail_r  <= '0;
      free_head_r <= '0;
      rel_head_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      bump_r      <= bump_nxt;
      free_v_r    <= free_v_nxt;
      rel_v_r     <= rel_v_nxt;
      rel_tail_r  <= rel_tail_nxt;
      free_head_r <= free_head_nxt;
      rel_head_r  <= rel_head_nxt;
    end
    cmd_r <= cmd_nxt;
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[wr_addr] <= tag_wd;
    end
    if (pend_we) begin
      pend_mem[wr_addr] <= pend_wd;
    end
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    tag_rd_r  <= tag_mem[rd_addr];
    pend_rd_r <= pend_mem[rd_addr];
    link_rd_r <= link_mem[rd_addr];
  end

  a_pop_has_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP |-> free_v_r)
    else $error("free stack pop with empty stack");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> state_r == S_IDLE)
    else $error("request taken while busy");

  a_bump_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bump_r <= (SW + 1)'(SLOTS))
    else $error("bump counter past slot count");

  a_look_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOOK |=> state_r == S_IDLE)
    else $error("lookup did not finish");

endmodule

// ===== hw/rtl/slot_allocator_deferred_free.sv =====
// top level of the slot allocator with deferred release
//
// Both channels behave as queues. A request is taken when in_push is high and
// in_full is low; a result is on out_status and out_slot_out while out_empty
// is low and leaves when out_pop is high. Every request gives one result, in
// request order.
// Requests are decoded and checked on entry and wait in a two-entry queue;
// the sequencer behind it serves one request at a time and writes into a
// two-entry result queue. Requests rejected on entry, allocations from the
// bump counter and reclaims are answered as the sequencer takes them; check
// and release first read the slot memories, a free-stack pop first reads the
// link memory, and an allocate that finds only the pending list splices it
// first and then pops; a pop needs the link memory read before the stack head
// moves. Reset is synchronous; no memory sweep follows, as the slot flags count
// as written only below the bump counter. When the receiver stops popping, the
// result queue fills, the sequencer holds and in_full rises once the request
// queue is full; nothing is dropped.
module slot_allocator_deferred_free #(
  parameter int SLOTS      = 1024,
  parameter int TYPE_COUNT = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [1:0] in_action,
  input  logic [1:0] in_type_code,
  input  logic [9:0] in_slot,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [2:0] out_status,
  output logic [9:0] out_slot_out
);

  localparam int CMDW = $bits(sad_pkg::cmd_t);
  localparam int RESW = $bits(sad_pkg::result_t);

  sad_pkg::cmd_t    cmd_in;
  sad_pkg::result_t res_out;
  logic [CMDW-1:0]  cmd_q;
  logic             cmd_empty, cmd_pop;
  logic [RESW-1:0]  res_d, res_q;
  logic             res_full, res_push;

  sad_front #(
    .SLOTS      (SLOTS),
    .TYPE_COUNT (TYPE_COUNT)
  ) u_front (
    .action    (in_action),
    .type_code (in_type_code),
    .slot      (in_slot),
    .cmd       (cmd_in)
  );

  sad_fifo #(
    .WIDTH (CMDW),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cmd_in),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (cmd_q),
    .empty (cmd_empty)
  );

  sad_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_data  (cmd_q),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_data  (res_d),
    .res_full  (res_full),
    .res_push  (res_push)
  );

  sad_fifo #(
    .WIDTH (RESW),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_d),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_q),
    .empty (out_empty)
  );

  assign res_out      = sad_pkg::result_t'(res_q);
  assign out_status   = res_out.status;
  assign out_slot_out = res_out.slot;

endmodule
